FILE: rtl/core/bdo_pkg.sv
package bdo_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = X_W + Y_W;

    localparam int RES_W      = 9;
    localparam int DEPTH_W    = 24;
    localparam int COEF_W     = 32;
    localparam int CFG_IDX_W  = 8;

    // Divider operands: the widest numerator is a Q16.16 value scaled by 2^24.
    localparam int NUM_W      = COEF_W + DEPTH_W;
    localparam int DEN_W      = COEF_W;

    localparam logic signed [COEF_W-1:0] NEAR_EPS   = 32'sd65;
    localparam logic [DEPTH_W-1:0]       DEPTH_BIAS = 24'd16777;

    localparam logic [CFG_IDX_W-1:0] CFG_RES_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_HEIGHT = 8'd1;

    typedef enum logic [1:0] {
        ACT_WRITE_DEPTH = 2'd0,
        ACT_LOAD_COEFF  = 2'd1,
        ACT_TEST_BOX    = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        VD_OCCLUDED   = 2'd0,
        VD_NEARER     = 2'd1,
        VD_NEAR_PLANE = 2'd2
    } verdict_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROJ_GO,
        ST_PROJ_WAIT,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RECT,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             done;
        logic             busy;
        logic             neg;
        logic             rem_nz;
        logic [NUM_W-1:0] quo;
    } div_res_t;

endpackage

FILE: rtl/core/bdo_depth_mem.sv
module bdo_depth_mem (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [bdo_pkg::ADDR_W-1:0]   wr_addr,
    input  logic [bdo_pkg::DEPTH_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [bdo_pkg::ADDR_W-1:0]   rd_addr,
    output logic [bdo_pkg::DEPTH_W-1:0]  rd_data
);
    import bdo_pkg::*;

    logic [DEPTH_W-1:0] depth_mem [2**ADDR_W];
    logic [DEPTH_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            depth_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= depth_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/bdo_div.sv
module bdo_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [bdo_pkg::NUM_W-1:0]  num,
    input  logic [bdo_pkg::DEN_W-1:0]         den,
    output bdo_pkg::div_res_t                 res
);
    import bdo_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   shifted;
    logic             fits;
    logic [DEN_W:0]   diff;

    // One quotient bit per cycle, restoring form on the magnitude.
    assign shifted = {rem_reg, q_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            neg_reg <= num[NUM_W-1];
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign res.done   = done_reg;
    assign res.busy   = busy_reg;
    assign res.neg    = neg_reg;
    assign res.rem_nz = |rem_reg;
    assign res.quo    = q_reg;

endmodule

FILE: rtl/core/bdo_proj.sv
module bdo_proj (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [3:0]                         wr_addr,
    input  logic signed [bdo_pkg::COEF_W-1:0]  wr_data,
    input  logic                               start,
    input  logic [1:0]                         col,
    input  logic signed [bdo_pkg::COEF_W-1:0]  px,
    input  logic signed [bdo_pkg::COEF_W-1:0]  py,
    input  logic signed [bdo_pkg::COEF_W-1:0]  pz,
    output logic                               done,
    output logic signed [bdo_pkg::COEF_W-1:0]  result
);
    import bdo_pkg::*;

    localparam int PROD_W = 2 * COEF_W;
    localparam int TERM_W = PROD_W - 16;
    localparam int ACC_W  = TERM_W + 2;

    logic signed [COEF_W-1:0] mat_mem [16];

    logic                     busy_reg;
    logic [1:0]               iss_reg;
    logic [1:0]               col_reg;
    logic signed [COEF_W-1:0] x_reg, y_reg, z_reg;
    logic signed [COEF_W-1:0] rd_data_reg;
    logic                     s1_vld_reg;
    logic [1:0]               s1_row_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     s2_vld_reg;
    logic [1:0]               s2_row_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     done_reg;
    logic signed [COEF_W-1:0] result_reg;

    logic signed [COEF_W-1:0] coord;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  sum;

    function automatic logic signed [COEF_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32'sh7fff_ffff);
        lo = ACC_W'(32'sh8000_0000);
        if (v > hi)
        begin
            return 32'sh7fff_ffff;
        end
        else if (v < lo)
        begin
            return 32'sh8000_0000;
        end
        return v[COEF_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mat_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            rd_data_reg <= mat_mem[{iss_reg, col_reg}];
        end
    end

    // The constant row of the matrix is multiplied by 1.0 so all four terms share one path.
    always_comb
    begin
        case (s1_row_reg)
            2'd0:    coord = x_reg;
            2'd1:    coord = y_reg;
            2'd2:    coord = z_reg;
            default: coord = 32'sd65536;
        endcase
    end

    assign term = ACC_W'(prod_reg >>> 16);
    assign sum  = acc_reg + term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            iss_reg    <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg   <= s2_vld_reg && (s2_row_reg == 2'd3);
            s1_vld_reg <= busy_reg;
            s2_vld_reg <= s1_vld_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                iss_reg  <= '0;
            end
            else if (busy_reg)
            begin
                iss_reg <= iss_reg + 1'b1;
                if (iss_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            col_reg <= col;
            x_reg   <= px;
            y_reg   <= py;
            z_reg   <= pz;
            acc_reg <= '0;
        end
        s1_row_reg <= iss_reg;
        prod_reg   <= rd_data_reg * coord;
        s2_row_reg <= s1_row_reg;
        if (s2_vld_reg)
        begin
            acc_reg <= sum;
            if (s2_row_reg == 2'd3)
            begin
                result_reg <= sat32(sum);
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg && !s1_vld_reg && !s2_vld_reg)
        else $error("projection restarted while a column was in flight");
    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !s1_vld_reg && !busy_reg)
        else $error("column finished with reads still pending");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_vld_reg && s2_row_reg == 2'd3) |=> done)
        else $error("last term accumulated without done");
`endif

endmodule

FILE: rtl/core/box_depth_occlusion_test_top.sv
// Box occlusion tester against a 256x256 depth buffer.
// Input items arrive on the s_ stream; s_tuser carries the action. A depth
// write or a matrix coefficient load gives no result, so such items stream at
// one per cycle while no box test runs. A box test gives one result item on
// the m_ stream: m_tdata[0] is visible, m_tuser the verdict.
// A box test projects up to eight corners. Each corner costs four column
// passes through the shared multiply-accumulate unit, a step to form the
// numerators and three divisions of 56 quotient bits each; a near-plane
// crossing ends the test at once. The covered pixels are then read from the
// depth memory one per cycle until a nearer one is found. No new item is
// taken while a box test runs.
// The finished result sits in an output register, so the next item is taken
// while it waits; a second result waits until the receiver takes the first.
// The resolution registers are written on the cfg_ channel (always ready).
// Reset sets both resolutions to 256 and empties the pipeline; depth and
// matrix contents are not cleared and must be written before use.
module box_depth_occlusion_test_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pix_x, pix_y, depth_value, coeff_index, coeff_value, box_min_x,
    // box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, zero pad
    input  logic [271:0]                       s_tdata,
    // action
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // visible, zero pad
    output logic [7:0]                         m_tdata,
    // verdict
    output logic [1:0]                         m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bdo_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bdo_pkg::RES_W-1:0]          cfg_data
);
    import bdo_pkg::*;

    localparam int QW = NUM_W + 2;

    state_t                   state_reg, state_next;
    logic [RES_W-1:0]         res_w_reg, res_h_reg;
    logic signed [COEF_W-1:0] bmin_x_reg, bmin_y_reg, bmin_z_reg;
    logic signed [COEF_W-1:0] bmax_x_reg, bmax_y_reg, bmax_z_reg;
    logic [2:0]               corner_reg;
    logic [1:0]               colstep_reg;
    logic [1:0]               divstep_reg;
    logic signed [COEF_W-1:0] w_reg, cx_reg, cy_reg, cz_reg;
    logic signed [NUM_W-1:0]  num_x_reg, num_y_reg, num_z_reg;
    logic [RES_W-1:0]         px0_reg, py0_reg;
    logic [X_W-1:0]           px1_reg;
    logic [Y_W-1:0]           py1_reg;
    logic signed [DEPTH_W+1:0] near_reg;
    logic [X_W-1:0]           sx_reg;
    logic [Y_W-1:0]           sy_reg;
    logic                     scan_iss_reg;
    logic                     rd_vld_reg;
    verdict_t                 verdict_reg;
    logic                     out_vld_reg;
    verdict_t                 out_verdict_reg;

    logic                     in_acc;
    action_t                  action;
    logic [RES_W-1:0]         rw, rh;
    logic                     proj_start, proj_done;
    logic signed [COEF_W-1:0] proj_res;
    logic [1:0]               proj_col;
    logic signed [COEF_W-1:0] cor_x, cor_y, cor_z;
    logic                     div_start;
    logic signed [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]         div_den;
    div_res_t                 div_res;
    logic signed [QW-1:0]     qs, q_floor, q_ceil;
    logic signed [COEF_W:0]   sum_x, dif_y;
    logic signed [COEF_W+RES_W+1:0] mx, my;
    logic                     rect_empty;
    logic [DEPTH_W-1:0]       depth_rd;
    logic signed [DEPTH_W+2:0] depth_lim;
    logic                     hit;
    logic                     out_load;

    function automatic logic [RES_W-1:0] eff_res(input logic [RES_W-1:0] r,
                                                 input logic [RES_W-1:0] rmax);
        if (r == '0)
        begin
            return RES_W'(1);
        end
        else if (r > rmax)
        begin
            return rmax;
        end
        return r;
    endfunction

    // Clamp a lower bound to [0, r].
    function automatic logic [RES_W-1:0] sat_lo(input logic signed [QW-1:0] v,
                                                input logic [RES_W-1:0] r);
        if (v < 0)
        begin
            return '0;
        end
        else if (v > $signed(QW'(r)))
        begin
            return r;
        end
        return v[RES_W-1:0];
    endfunction

    // Clamp an upper bound to [0, r-1].
    function automatic logic [RES_W-2:0] sat_hi(input logic signed [QW-1:0] v,
                                                input logic [RES_W-1:0] r);
        logic [RES_W-1:0] rm1;
        rm1 = r - 1'b1;
        if (v < 0)
        begin
            return '0;
        end
        else if (v > $signed(QW'(rm1)))
        begin
            return rm1[RES_W-2:0];
        end
        return v[RES_W-2:0];
    endfunction

    // Anything below zero compares the same as -1, anything above 1.0 never wins the minimum.
    function automatic logic signed [DEPTH_W+1:0] sat_z(input logic signed [QW-1:0] v);
        if (v < -1)
        begin
            return '1;
        end
        else if (v > $signed(QW'(1 << DEPTH_W)))
        begin
            return (DEPTH_W+2)'(1 << DEPTH_W);
        end
        return v[DEPTH_W+1:0];
    endfunction

    assign in_acc = s_tvalid && s_tready;
    assign action = action_t'(s_tuser);
    assign rw     = eff_res(res_w_reg, RES_W'(MAX_WIDTH));
    assign rh     = eff_res(res_h_reg, RES_W'(MAX_HEIGHT));
    assign cfg_ready = 1'b1;

    assign cor_x    = corner_reg[2] ? bmax_x_reg : bmin_x_reg;
    assign cor_y    = corner_reg[1] ? bmax_y_reg : bmin_y_reg;
    assign cor_z    = corner_reg[0] ? bmax_z_reg : bmin_z_reg;
    // w first, so a near-plane corner stops the test early.
    assign proj_col = (colstep_reg == 2'd0) ? 2'd3 : colstep_reg - 2'd1;

    assign sum_x = $signed({cx_reg[COEF_W-1], cx_reg}) + $signed({w_reg[COEF_W-1], w_reg});
    assign dif_y = $signed({w_reg[COEF_W-1], w_reg}) - $signed({cy_reg[COEF_W-1], cy_reg});
    assign mx    = $signed({1'b0, rw}) * sum_x;
    assign my    = $signed({1'b0, rh}) * dif_y;

    always_comb
    begin
        case (divstep_reg)
            2'd0:    div_num = num_x_reg;
            2'd1:    div_num = num_y_reg;
            default: div_num = num_z_reg;
        endcase
    end
    assign div_den = (divstep_reg == 2'd2) ? DEN_W'(w_reg) : {w_reg[COEF_W-2:0], 1'b0};

    assign qs      = $signed({2'b00, div_res.quo});
    assign q_floor = div_res.neg ? -qs - QW'(div_res.rem_nz) : qs;
    assign q_ceil  = div_res.neg ? -qs : qs + QW'(div_res.rem_nz);

    assign rect_empty = (px0_reg > {1'b0, px1_reg}) || (py0_reg > {1'b0, py1_reg});
    assign depth_lim  = $signed({3'b000, depth_rd}) + $signed({3'b000, DEPTH_BIAS});
    assign hit        = rd_vld_reg && ((DEPTH_W+3)'(near_reg) < depth_lim);
    assign out_load   = (state_reg == ST_DONE) && (!out_vld_reg || m_tready);

    bdo_proj u_proj (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_acc && action == ACT_LOAD_COEFF),
        .wr_addr (s_tdata[43:40]),
        .wr_data (s_tdata[75:44]),
        .start   (proj_start),
        .col     (proj_col),
        .px      (cor_x),
        .py      (cor_y),
        .pz      (cor_z),
        .done    (proj_done),
        .result  (proj_res)
    );

    bdo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .res   (div_res)
    );

    bdo_depth_mem u_depth (
        .clk     (clk),
        .wr_en   (in_acc && action == ACT_WRITE_DEPTH),
        .wr_addr ({s_tdata[8 +: Y_W], s_tdata[0 +: X_W]}),
        .wr_data (s_tdata[39:16]),
        .rd_en   ((state_reg == ST_SCAN) && scan_iss_reg),
        .rd_addr ({sy_reg, sx_reg}),
        .rd_data (depth_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        proj_start = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_acc && action == ACT_TEST_BOX)
                begin
                    state_next = ST_PROJ_GO;
                end
            end
            ST_PROJ_GO:
            begin
                proj_start = 1'b1;
                state_next = ST_PROJ_WAIT;
            end
            ST_PROJ_WAIT:
            begin
                if (proj_done)
                begin
                    if (colstep_reg == 2'd0 && proj_res <= NEAR_EPS)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (colstep_reg == 2'd3)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_PROJ_GO;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_res.done)
                begin
                    if (divstep_reg != 2'd2)
                    begin
                        state_next = ST_DIV_GO;
                    end
                    else if (corner_reg == 3'd7)
                    begin
                        state_next = ST_RECT;
                    end
                    else
                    begin
                        state_next = ST_PROJ_GO;
                    end
                end
            end
            ST_RECT:
            begin
                state_next = rect_empty ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (hit || (!scan_iss_reg && !rd_vld_reg))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_w_reg    <= RES_W'(MAX_WIDTH);
            res_h_reg    <= RES_W'(MAX_HEIGHT);
            out_vld_reg  <= 1'b0;
            scan_iss_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_RES_WIDTH)
                begin
                    res_w_reg <= cfg_data;
                end
                else if (cfg_index == CFG_RES_HEIGHT)
                begin
                    res_h_reg <= cfg_data;
                end
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (state_reg == ST_RECT)
            begin
                scan_iss_reg <= !rect_empty;
                rd_vld_reg   <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                rd_vld_reg <= scan_iss_reg && !hit;
                if (hit)
                begin
                    scan_iss_reg <= 1'b0;
                end
                else if (scan_iss_reg && sx_reg == px1_reg && sy_reg == py1_reg)
                begin
                    scan_iss_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_verdict_reg <= verdict_reg;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && action == ACT_TEST_BOX)
                begin
                    bmin_x_reg  <= s_tdata[107:76];
                    bmin_y_reg  <= s_tdata[139:108];
                    bmin_z_reg  <= s_tdata[171:140];
                    bmax_x_reg  <= s_tdata[203:172];
                    bmax_y_reg  <= s_tdata[235:204];
                    bmax_z_reg  <= s_tdata[267:236];
                    corner_reg  <= '0;
                    colstep_reg <= '0;
                    divstep_reg <= '0;
                    px0_reg     <= rw;
                    py0_reg     <= rh;
                    px1_reg     <= '0;
                    py1_reg     <= '0;
                    near_reg    <= (DEPTH_W+2)'(1 << DEPTH_W);
                end
            end
            ST_PROJ_WAIT:
            begin
                if (proj_done)
                begin
                    colstep_reg <= colstep_reg + 1'b1;
                    case (colstep_reg)
                        2'd0:    w_reg  <= proj_res;
                        2'd1:    cx_reg <= proj_res;
                        2'd2:    cy_reg <= proj_res;
                        default: cz_reg <= proj_res;
                    endcase
                    if (colstep_reg == 2'd0 && proj_res <= NEAR_EPS)
                    begin
                        verdict_reg <= VD_NEAR_PLANE;
                    end
                end
            end
            ST_MUL:
            begin
                num_x_reg   <= NUM_W'(mx);
                num_y_reg   <= NUM_W'(my);
                num_z_reg   <= {cz_reg, {DEPTH_W{1'b0}}};
                divstep_reg <= '0;
            end
            ST_DIV_WAIT:
            begin
                if (div_res.done)
                begin
                    case (divstep_reg)
                        2'd0:
                        begin
                            if (sat_lo(q_floor, rw) < px0_reg)
                            begin
                                px0_reg <= sat_lo(q_floor, rw);
                            end
                            if (sat_hi(q_ceil, rw) > px1_reg)
                            begin
                                px1_reg <= sat_hi(q_ceil, rw);
                            end
                        end
                        2'd1:
                        begin
                            if (sat_lo(q_floor, rh) < py0_reg)
                            begin
                                py0_reg <= sat_lo(q_floor, rh);
                            end
                            if (sat_hi(q_ceil, rh) > py1_reg)
                            begin
                                py1_reg <= sat_hi(q_ceil, rh);
                            end
                        end
                        default:
                        begin
                            if (sat_z(q_floor) < near_reg)
                            begin
                                near_reg <= sat_z(q_floor);
                            end
                        end
                    endcase
                    divstep_reg <= divstep_reg + 1'b1;
                    if (divstep_reg == 2'd2)
                    begin
                        corner_reg  <= corner_reg + 1'b1;
                        colstep_reg <= '0;
                    end
                end
            end
            ST_RECT:
            begin
                sx_reg      <= px0_reg[X_W-1:0];
                sy_reg      <= py0_reg[Y_W-1:0];
                verdict_reg <= VD_OCCLUDED;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    verdict_reg <= VD_NEARER;
                end
                if (scan_iss_reg)
                begin
                    if (sx_reg == px1_reg)
                    begin
                        sx_reg <= px0_reg[X_W-1:0];
                        sy_reg <= sy_reg + 1'b1;
                    end
                    else
                    begin
                        sx_reg <= sx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_verdict_reg != VD_OCCLUDED};
    assign m_tuser  = out_verdict_reg;

`ifndef SYNTHESIS
    a_scan_in_rect: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && scan_iss_reg) |->
            ({1'b0, sx_reg} >= px0_reg) && (sx_reg <= px1_reg) &&
            ({1'b0, sy_reg} >= py0_reg) && (sy_reg <= py1_reg))
        else $error("depth scan left the covered rectangle");
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_res.busy)
        else $error("divider started while busy");
    a_proj_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        proj_done |-> state_reg == ST_PROJ_WAIT)
        else $error("projection result arrived outside its wait state");
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_vld_reg && !m_tready) |=> state_reg == ST_DONE)
        else $error("result left while the output register was full");
`endif

endmodule
